/* sv/pli_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the positional list core: command and
// status codes, transfer payloads, and the control word broadcast to cells.
// ---------------------------------------------------------------------------
package pli_pkg;

    // list capacity and derived widths
    localparam int CAPACITY    = 64;
    localparam int POS_W       = $clog2(CAPACITY);
    localparam int IDX_W       = 7;
    localparam int LEN_W       = 7;
    localparam int DATA_W      = 32;
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    // command codes
    typedef enum logic [2:0] {
        CMD_SET_LEN = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_READ    = 3'd4
    } cmd_e;

    // status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_e;

    // operation applied by every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } cell_op_e;

    typedef struct packed {
        logic [2:0]               command;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [LEN_W-1:0]         current_length;
        logic signed [DATA_W-1:0] read_value;
    } rsp_item_t;

    // control broadcast from the top level to the row of cells
    // lim bounds the shift: last slot filled on insert, last slot vacated on delete
    typedef struct packed {
        cell_op_e                 op;
        logic                     rd;
        logic [POS_W-1:0]         pos;
        logic [POS_W-1:0]         lim;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

/* sv/pli_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pli_cell
// One list slot. Compares its own position with the broadcast position and
// shift limit and takes the new value, its left neighbor or its right neighbor, or holds.
// ---------------------------------------------------------------------------
module pli_cell (
    input  logic                              clk,
    input  logic [pli_pkg::POS_W-1:0]         slot_id,
    input  pli_pkg::cell_ctrl_t               ctrl,
    input  logic signed [pli_pkg::DATA_W-1:0] left,
    input  logic signed [pli_pkg::DATA_W-1:0] right,
    output logic signed [pli_pkg::DATA_W-1:0] data,
    output logic signed [pli_pkg::DATA_W-1:0] rd_word
);
    import pli_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     hit;
    logic                     above;
    logic                     in_span;
    logic                     below_lim;

    // position compare
    assign hit       = (slot_id == ctrl.pos);
    assign above     = (slot_id > ctrl.pos);
    assign in_span   = (slot_id <= ctrl.lim);
    assign below_lim = (slot_id < ctrl.lim);

    // next slot contents
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_WRITE:
            begin
                if (hit)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_INSERT:
            begin
                if (hit)
                begin
                    data_next = ctrl.value;
                end
                else if (above && in_span)
                begin
                    data_next = left;
                end
            end
            CELL_DELETE:
            begin
                if ((hit || above) && below_lim)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // slot storage, undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_word = (ctrl.rd && hit) ? data_reg : '0;

endmodule

/* sv/pli_read_tree.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pli_read_tree
// Two-level OR tree over the masked cell words: group partials are
// registered on command transfer, the final OR feeds the response register.
// ---------------------------------------------------------------------------
module pli_read_tree (
    input  logic                              clk,
    input  logic                              load,
    input  logic signed [pli_pkg::DATA_W-1:0] words [pli_pkg::CAPACITY],
    output logic signed [pli_pkg::DATA_W-1:0] result
);
    import pli_pkg::*;

    logic [DATA_W-1:0] group_reg  [NUM_GROUPS];
    logic [DATA_W-1:0] group_next [NUM_GROUPS];

    // first level: OR within each group
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int i = 0; i < GROUP_SIZE; i++)
            begin
                if (g * GROUP_SIZE + i < CAPACITY)
                begin
                    group_next[g] = group_next[g] | words[g * GROUP_SIZE + i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            group_reg <= group_next;
        end
    end

    // second level: OR across groups
    always_comb
    begin
        result = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            result = result | group_reg[g];
        end
    end

endmodule

/* sv/positional_list_insert_delete_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_list_insert_delete_core
// Fixed-capacity ordered list with 1-based positions: set length, write,
// insert, delete and read, one response per command.
// ---------------------------------------------------------------------------
// A command is taken every cycle while the response side keeps up; its
// status and length are registered on transfer and move into the response
// register once that is empty or not stalled. All slots sit in a row of
// cells that compare their position with the command and shift toward a
// neighbor in the transfer cycle, so insert and delete cost no more than
// write; slots past the list length are left untouched. A read passes
// through a two-level OR tree with a register between the levels.
// Slot contents are undefined after reset; the length resets to zero.
module positional_list_insert_delete_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  pli_pkg::cmd_item_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output pli_pkg::rsp_item_t rsp
);
    import pli_pkg::*;

    logic [LEN_W-1:0]         length_reg;
    logic [LEN_W-1:0]         length_next;
    logic                     s1_valid_reg;
    logic [1:0]               s1_status_reg;
    logic [LEN_W-1:0]         s1_length_reg;
    logic                     rsp_valid_reg;
    rsp_item_t                rsp_reg;

    logic                     cmd_xfer;
    logic                     s1_move;
    logic                     in_range;
    logic                     ins_range;
    logic [1:0]               status_next;
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] slot_data [CAPACITY];
    logic signed [DATA_W-1:0] slot_rd   [CAPACITY];
    logic signed [DATA_W-1:0] tree_out;

    // handshake
    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = s1_valid_reg && !s1_move;
    assign cmd_xfer  = cmd_valid && !cmd_stall;

    // position checks
    assign in_range  = (cmd.index != '0) && (cmd.index <= IDX_W'(length_reg));
    assign ins_range = (cmd.index != '0)
                       && ({1'b0, cmd.index} <= ({1'b0, IDX_W'(length_reg)} + 8'd1));

    // command decode
    always_comb
    begin
        length_next = length_reg;
        status_next = ST_RANGE;
        ctrl.op     = CELL_HOLD;
        ctrl.rd     = 1'b0;
        ctrl.pos    = POS_W'(cmd.index - IDX_W'(1));
        ctrl.lim    = '0;
        ctrl.value  = cmd.value;
        unique case (cmd.command)
            CMD_SET_LEN:
            begin
                if ({1'b0, cmd.index} <= (IDX_W + 1)'(CAPACITY))
                begin
                    length_next = LEN_W'(cmd.index);
                    status_next = ST_OK;
                end
            end
            CMD_WRITE:
            begin
                if (in_range)
                begin
                    ctrl.op     = CELL_WRITE;
                    status_next = ST_OK;
                end
            end
            CMD_INSERT:
            begin
                if ({1'b0, length_reg} >= (LEN_W + 1)'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else if (ins_range)
                begin
                    ctrl.op     = CELL_INSERT;
                    ctrl.lim    = POS_W'(length_reg);
                    length_next = length_reg + LEN_W'(1);
                    status_next = ST_OK;
                end
            end
            CMD_DELETE:
            begin
                if (in_range)
                begin
                    ctrl.op     = CELL_DELETE;
                    ctrl.lim    = POS_W'(length_reg - LEN_W'(1));
                    length_next = length_reg - LEN_W'(1);
                    status_next = ST_OK;
                end
            end
            CMD_READ:
            begin
                if (in_range)
                begin
                    ctrl.rd     = 1'b1;
                    status_next = ST_OK;
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
        if (!cmd_xfer)
        begin
            ctrl.op = CELL_HOLD;
        end
    end

    // row of cells
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_slot
        logic signed [DATA_W-1:0] left_w;
        logic signed [DATA_W-1:0] right_w;

        if (k == 0)
        begin : g_first
            assign left_w = slot_data[k];
        end
        else
        begin : g_inner_l
            assign left_w = slot_data[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_w = slot_data[k];
        end
        else
        begin : g_inner_r
            assign right_w = slot_data[k+1];
        end

        pli_cell u_slot (
            .clk     (clk),
            .slot_id (POS_W'(k)),
            .ctrl    (ctrl),
            .left    (left_w),
            .right   (right_w),
            .data    (slot_data[k]),
            .rd_word (slot_rd[k])
        );
    end

    // read select
    pli_read_tree u_read_tree (
        .clk    (clk),
        .load   (cmd_xfer),
        .words  (slot_rd),
        .result (tree_out)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_xfer)
            begin
                length_reg <= length_next;
            end
            if (cmd_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            s1_status_reg <= status_next;
            s1_length_reg <= length_next;
        end
        if (s1_move)
        begin
            rsp_reg.status         <= s1_status_reg;
            rsp_reg.current_length <= s1_length_reg;
            rsp_reg.read_value     <= tree_out;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* sv/pli_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pli_checker
// Port-level checks for the positional list core, bound to the top level.
// ---------------------------------------------------------------------------
module pli_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input pli_pkg::rsp_item_t rsp
);
    import pli_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // reported length never exceeds capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, rsp.current_length} <= (LEN_W + 1)'(CAPACITY)))
        else $error("length above capacity");

    // a full rejection only happens at capacity
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL)
        |-> ({1'b0, rsp.current_length} == (LEN_W + 1)'(CAPACITY)))
        else $error("full status below capacity");

    // read data only comes with a successful command
    a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.read_value != '0) |-> (rsp.status == ST_OK))
        else $error("read data on a failed command");

endmodule

bind positional_list_insert_delete_core pli_checker u_pli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
